@@ rtl/etge_pkg.sv @@
// ----------------------------------------------------------------------------
// etge_pkg
// Shared types and character constants for the escaped token and group
// extractor.
// ----------------------------------------------------------------------------
package etge_pkg;

  // Extraction phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PLEAD = 3'd1;
  localparam logic [2:0] PH_PBODY = 3'd2;
  localparam logic [2:0] PH_PTRAIL = 3'd3;
  localparam logic [2:0] PH_GLEAD = 3'd4;
  localparam logic [2:0] PH_GBODY = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CU_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CU_CLOSE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Extraction state apart from the nesting depth.
  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] delim;
    logic       incl;
    logic       square;
    logic       prev_bs;
    logic       esc;
  } ext_st_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       keep;
    logic       consumed;
    logic       done;
    logic       status;
  } ext_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

@@ rtl/etge_step.sv @@
// ----------------------------------------------------------------------------
// etge_step
// Next-state and result logic for one text character.
// ----------------------------------------------------------------------------
module etge_step import etge_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
  input  ext_st_t            cur_st_i,
  input  logic [DEPTH_W-1:0] cur_depth_i,
  input  logic [7:0]         ch_i,
  input  logic               start_i,
  input  logic               group_i,
  input  logic [7:0]         delim_i,
  input  logic               incl_i,
  output ext_st_t            nxt_st_o,
  output logic [DEPTH_W-1:0] nxt_depth_o,
  output ext_res_t           res_o
);

  localparam logic [DEPTH_W-1:0] DepthMax = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DepthOne = DEPTH_W'(1);

  ext_st_t            st;
  logic [DEPTH_W-1:0] depth;

  // Plain body evaluation, shared by the plain phases and the group fallback.
  logic [7:0] pb_delim;
  logic       pb_prev;
  logic       pb_term;

  logic [7:0] opener;
  logic [7:0] closer;
  logic [DEPTH_W-1:0] depth_dec;

  // State after a possible start of a new extraction.
  always_comb begin
    st    = cur_st_i;
    depth = cur_depth_i;
    if (start_i) begin
      st.phase   = group_i ? PH_GLEAD : PH_PLEAD;
      st.delim   = delim_i;
      st.incl    = incl_i;
      st.square  = 1'b0;
      st.prev_bs = 1'b0;
      st.esc     = 1'b0;
      depth      = '0;
    end
  end

  assign pb_delim  = (st.phase == PH_GLEAD) ? CH_NUL : st.delim;
  assign pb_prev   = (st.phase == PH_PBODY) ? st.prev_bs : 1'b0;
  assign pb_term   = (pb_delim == CH_NUL) ? is_ws(ch_i) : (ch_i == pb_delim);
  assign opener    = st.square ? CH_SQ_OPEN : CH_CU_OPEN;
  assign closer    = st.square ? CH_SQ_CLOSE : CH_CU_CLOSE;
  assign depth_dec = depth - DepthOne;

  always_comb begin
    nxt_st_o    = st;
    nxt_depth_o = depth;
    res_o       = '0;

    unique case (st.phase)
      PH_PLEAD, PH_PBODY, PH_GLEAD: begin
        if (ch_i == CH_NUL) begin
          // End of text ends the extraction cleanly, except inside a group body.
          res_o.done     = 1'b1;
          nxt_st_o.phase = PH_IDLE;
          nxt_st_o.esc   = 1'b0;
          nxt_st_o.prev_bs = 1'b0;
          nxt_depth_o    = '0;
        end else if (st.phase != PH_PBODY && is_ws(ch_i)) begin
          res_o.consumed = 1'b1;
        end else if (st.phase == PH_GLEAD &&
                     (ch_i == CH_SQ_OPEN || ch_i == CH_CU_OPEN)) begin
          nxt_st_o.square = (ch_i == CH_SQ_OPEN);
          nxt_st_o.esc    = 1'b0;
          nxt_st_o.phase  = PH_GBODY;
          nxt_depth_o     = DepthOne;
          res_o.consumed  = 1'b1;
          if (st.incl) begin
            res_o.keep     = 1'b1;
            res_o.out_char = ch_i;
          end
        end else begin
          nxt_st_o.delim = pb_delim;
          res_o.consumed = 1'b1;
          if (pb_term && !pb_prev) begin
            nxt_st_o.phase   = PH_PTRAIL;
            nxt_st_o.prev_bs = 1'b0;
          end else begin
            nxt_st_o.phase   = PH_PBODY;
            nxt_st_o.prev_bs = (ch_i == CH_BSLASH);
            if (ch_i != CH_BSLASH) begin
              res_o.keep     = 1'b1;
              res_o.out_char = ch_i;
            end
          end
        end
      end
      PH_PTRAIL: begin
        if (ch_i != CH_NUL && is_ws(ch_i)) begin
          res_o.consumed = 1'b1;
        end else begin
          res_o.done       = 1'b1;
          nxt_st_o.phase   = PH_IDLE;
          nxt_st_o.esc     = 1'b0;
          nxt_st_o.prev_bs = 1'b0;
          nxt_depth_o      = '0;
        end
      end
      PH_GBODY: begin
        if (ch_i == CH_NUL) begin
          // Unclosed group or dangling escape.
          res_o.done       = 1'b1;
          res_o.status     = 1'b1;
          nxt_st_o.phase   = PH_IDLE;
          nxt_st_o.esc     = 1'b0;
          nxt_st_o.prev_bs = 1'b0;
          nxt_depth_o      = '0;
        end else begin
          res_o.consumed = 1'b1;
          if (st.esc) begin
            nxt_st_o.esc   = 1'b0;
            res_o.keep     = 1'b1;
            res_o.out_char = ch_i;
          end else if (ch_i == CH_BSLASH) begin
            nxt_st_o.esc = 1'b1;
          end else if (ch_i == opener) begin
            if (depth >= DepthMax) begin
              res_o.done       = 1'b1;
              res_o.status     = 1'b1;
              nxt_st_o.phase   = PH_IDLE;
              nxt_st_o.prev_bs = 1'b0;
              nxt_depth_o      = '0;
            end else begin
              nxt_depth_o    = depth + DepthOne;
              res_o.keep     = 1'b1;
              res_o.out_char = ch_i;
            end
          end else if (ch_i == closer && depth_dec == '0) begin
            // Outermost closer: kept and consumed only on request.
            res_o.consumed   = st.incl;
            res_o.keep       = st.incl;
            res_o.out_char   = st.incl ? ch_i : CH_NUL;
            res_o.done       = 1'b1;
            nxt_st_o.phase   = PH_IDLE;
            nxt_st_o.prev_bs = 1'b0;
            nxt_depth_o      = '0;
          end else begin
            if (ch_i == closer) begin
              nxt_depth_o = depth_dec;
            end
            res_o.keep     = 1'b1;
            res_o.out_char = ch_i;
          end
        end
      end
      default: begin
        nxt_st_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/escaped_token_and_group_extractor_top.sv @@
// ----------------------------------------------------------------------------
// escaped_token_and_group_extractor_top
// Streaming token and bracketed group extractor, one character per item.
// ----------------------------------------------------------------------------
// The block takes one text character per item and returns one result item for
// each. It sustains one item per clock cycle while out_ready_i does not stall
// the result register; an accepted item waits in the input register until its
// result is written into the result register. The extraction state advances
// as an item moves from the input register to the result register, so
// throughput is set by that single step and by result-side back-pressure only.
module escaped_token_and_group_extractor_top import etge_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       start_req_i,
  input  logic       group_mode_i,
  input  logic [7:0] delimiter_i,
  input  logic       include_outer_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       keep_o,
  output logic       consumed_o,
  output logic       done_res_o,
  output logic       status_o
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  // Input register.
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       start_q;
  logic       group_q;
  logic [7:0] delim_q;
  logic       incl_q;

  // Extraction state.
  ext_st_t            st_q, st_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  // Result register.
  logic     out_vld_q;
  ext_res_t res_q, res_d;

  logic advance;
  logic in_fire;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  etge_step #(
    .MAX_DEPTH(MAX_DEPTH),
    .DEPTH_W  (DEPTH_W)
  ) u_step (
    .cur_st_i   (st_q),
    .cur_depth_i(depth_q),
    .ch_i       (ch_q),
    .start_i    (start_q),
    .group_i    (group_q),
    .delim_i    (delim_q),
    .incl_i     (incl_q),
    .nxt_st_o   (st_d),
    .nxt_depth_o(depth_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
      depth_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
        depth_q   <= depth_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q    <= ch_i;
      start_q <= start_req_i;
      group_q <= group_mode_i;
      delim_q <= delimiter_i;
      incl_q  <= include_outer_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = res_q.out_char;
  assign keep_o      = res_q.keep;
  assign consumed_o  = res_q.consumed;
  assign done_res_o  = res_q.done;
  assign status_o    = res_q.status;

  // A syntax error is only ever reported together with the end of an extraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> done_res_o)
    else $error("status raised without done");

  // A kept character always belongs to the extraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && keep_o |-> consumed_o)
    else $error("kept character not consumed");

  // Nesting depth is non-zero exactly while inside a group body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_GBODY) == (depth_q != '0))
    else $error("depth out of step with phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_DEPTH))
    else $error("depth beyond limit");

endmodule
